// ===== src/lzss_window_decoder_core_assert.svh =====
// Assertion macros for the LZSS window decoder checker.
`ifndef LZSS_WINDOW_DECODER_CORE_ASSERT_SVH
`define LZSS_WINDOW_DECODER_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent.
`define LZSSWD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lzsswd assertion failed");

// Condition must hold in the cycle after the antecedent.
`define LZSSWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzsswd assertion failed");

`endif

// ===== src/lzsswd_pkg.sv =====
// Types and constants for the LZSS window decoder.
package lzsswd_pkg;

  localparam int unsigned WinSize  = 256;
  localparam int unsigned MaxMatch = 17;
  localparam int unsigned MinMatch = 2;
  localparam int unsigned PtrW     = $clog2(WinSize);
  localparam int unsigned CntW     = $clog2(MaxMatch + 1);
  localparam int unsigned TotalW   = 32;
  localparam logic [PtrW-1:0] WpReset = PtrW'(WinSize - MaxMatch);

  typedef enum logic [1:0] {
    StIdle,
    StLit,
    StCopy
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic lit_mode;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic slot_free;
    logic last;
  } dp_status_t;

endpackage

// ===== src/lzsswd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzsswd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lzsswd_ctrl.sv =====
// Token sequencer: accepts tokens and steps through literal and copy bytes.
module lzsswd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   is_literal_i,
  output logic                   in_ready_o,
  input  lzsswd_pkg::dp_status_t status_i,
  output lzsswd_pkg::ctrl_cmd_t  cmd_o
);
  import lzsswd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && !status_i.done) begin
          state_d = is_literal_i ? StLit : StCopy;
        end
      end
      StLit, StCopy: begin
        if (status_i.slot_free && status_i.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.lit_mode = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        // tokens after the stream is complete are taken and dropped
        cmd_o.load = in_valid_i && !status_i.done;
      end
      StLit: begin
        cmd_o.emit     = status_i.slot_free;
        cmd_o.lit_mode = 1'b1;
      end
      StCopy: begin
        cmd_o.emit = status_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/lzsswd_dp.sv =====
// Datapath: history ring, pointers, byte counter and output register.
module lzsswd_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lzsswd_pkg::TotalW-1:0]      cfg_wdata_i,
  input  logic [7:0]                         token_value_i,
  input  logic [3:0]                         length_code_i,
  input  lzsswd_pkg::ctrl_cmd_t              cmd_i,
  output lzsswd_pkg::dp_status_t             status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         out_byte_o,
  output logic                               last_of_run_o,
  output logic                               stream_done_o
);
  import lzsswd_pkg::*;

  logic [PtrW-1:0]   src_q, src_d;
  logic [CntW-1:0]   cnt_q;
  logic [PtrW-1:0]   wp_q;
  logic [TotalW-1:0] bytes_q, total_q, bytes_inc;
  logic [WinSize-1:0] valid_q;
  logic              vld_rd_q;
  logic              byp_q;
  logic [7:0]        byp_data_q;
  logic [7:0]        ram_rdata;
  logic [7:0]        rd_byte, emit_byte;
  logic              hit_total, last_byte;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q, out_done_q;

  // Source pointer; the RAM reads at the next pointer so data lines up with src_q
  always_comb begin
    src_d = src_q;
    if (cmd_i.load) begin
      src_d = token_value_i;
    end else if (cmd_i.emit) begin
      src_d = src_q + PtrW'(1);
    end
  end

  lzsswd_ram #(
    .WIDTH(8),
    .DEPTH(WinSize)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.emit),
    .waddr_i(wp_q),
    .wdata_i(emit_byte),
    .raddr_i(src_d),
    .rdata_o(ram_rdata)
  );

  // Read data: forward a byte written in the same cycle it was read,
  // entries not written since restart read as zero
  assign rd_byte   = byp_q ? byp_data_q : (vld_rd_q ? ram_rdata : 8'd0);
  assign emit_byte = cmd_i.lit_mode ? src_q : rd_byte;

  assign bytes_inc = bytes_q + TotalW'(1);
  assign hit_total = (bytes_inc == total_q);
  assign last_byte = cmd_i.lit_mode || (cnt_q == CntW'(1)) || hit_total;

  assign status_o.done      = (bytes_q == total_q);
  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign status_o.last      = last_byte;

  // Token registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    vld_rd_q   <= valid_q[src_d];
    byp_data_q <= emit_byte;
    if (cmd_i.load) begin
      cnt_q <= CntW'(length_code_i) + CntW'(MinMatch);
    end else if (cmd_i.emit) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Stream state and valid flags; a configuration write restarts the stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      bytes_q <= '0;
      wp_q    <= WpReset;
      valid_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      byp_q <= cmd_i.emit && (src_d == wp_q);
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
        bytes_q <= '0;
        wp_q    <= WpReset;
        valid_q <= '0;
      end else if (cmd_i.emit) begin
        bytes_q       <= bytes_inc;
        wp_q          <= wp_q + PtrW'(1);
        valid_q[wp_q] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= last_byte;
      out_done_q <= hit_total;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign stream_done_o = out_done_q;

endmodule

// ===== src/lzss_window_decoder_core.sv =====
// LZSS window decoder: a literal gives one byte, a copy up to length code + 2 bytes.
// Within a token, bytes go out at one byte per cycle while the output is not stalled,
// set by the single read port of the history ring and the byte-to-byte dependency of
// overlapping copies; a new token is accepted only in the idle state. Reset and
// configuration writes clear the ring at once through per-entry valid flags; there is
// no clearing pass. Output total resets to zero, so no byte is produced.
module lzss_window_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lzsswd_pkg::TotalW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          is_literal_i,
  input  logic [7:0]                    token_value_i,
  input  logic [3:0]                    length_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_of_run_o,
  output logic                          stream_done_o
);
  import lzsswd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lzsswd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_literal_i(is_literal_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lzsswd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .token_value_i(token_value_i),
    .length_code_i(length_code_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o),
    .stream_done_o(stream_done_o)
  );

endmodule

// ===== src/lzsswd_checker.sv =====
// Port-level checker for the LZSS window decoder, bound to the top level.
`include "lzss_window_decoder_core_assert.svh"

module lzsswd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        last_of_run_o,
  input logic        stream_done_o
);

  logic       out_fire;
  logic       done_seen_q;
  logic [4:0] run_q;

  assign out_fire = out_valid_o && out_ready_i;

  // Stream completed and no restart since
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (cfg_we_i) begin
      done_seen_q <= 1'b0;
    end else if (out_fire && stream_done_o) begin
      done_seen_q <= 1'b1;
    end
  end

  // Bytes delivered so far in the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_fire) begin
      run_q <= last_of_run_o ? 5'd0 : run_q + 5'd1;
    end
  end

  `LZSSWD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                      out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o))
  `LZSSWD_ASSERT_SAME(a_done_is_last, out_valid_o && stream_done_o, last_of_run_o)
  `LZSSWD_ASSERT_SAME(a_quiet_after_done, done_seen_q, !out_valid_o)
  `LZSSWD_ASSERT_SAME(a_run_max, out_valid_o && run_q == 5'd16, last_of_run_o)

endmodule

bind lzss_window_decoder_core lzsswd_checker u_checker (.*);
